// ----- sv/atcw_pkg.sv -----
// Package with shared constants, types and functions of the ANSI text console writer.
package atcw_pkg;

  localparam int unsigned Columns = 80;
  localparam int unsigned Rows = 25;
  localparam int unsigned MaxArgs = 6;

  localparam int unsigned PosW = 11;
  localparam int unsigned ArgW = 16;
  localparam int unsigned AttrW = 16;

  localparam logic [1:0] KindCell = 2'd0;
  localparam logic [1:0] KindScroll = 2'd1;
  localparam logic [1:0] KindCursor = 2'd2;

  localparam logic [1:0] PhaseText = 2'd0;
  localparam logic [1:0] PhaseEsc = 2'd1;
  localparam logic [1:0] PhaseCsi = 2'd2;

  localparam logic [AttrW-1:0] AttrReset = 16'h0700;

  typedef struct packed {
    logic [1:0]  kind;
    logic [10:0] cell_index;
    logic [15:0] cell_value;
    logic [15:0] cursor_position;
    logic        last;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic byte_load;  // decode the accepted byte
    logic sgr_apply;  // apply the argument selected by sgr_sel
    logic scroll;     // move write position back one row
  } cmd_t;

  typedef struct packed {
    logic need_sgr;     // byte ends an SGR sequence
    logic need_cursor;  // byte ends a cursor sequence
    logic need_cell;    // byte writes a cell
    logic need_scroll;  // position past scroll limit
  } status_t;

  function automatic logic [AttrW-1:0] apply_sgr(logic [AttrW-1:0] a_in, logic [ArgW-1:0] v);
    logic [AttrW-1:0] a;
    logic [AttrW-1:0] fg;
    logic [AttrW-1:0] bg;
    logic             fg_v;
    logic             bg_v;
    a = a_in;
    fg = '0;
    bg = '0;
    fg_v = 1'b0;
    bg_v = 1'b0;
    unique case (v)
      16'd0: a = 16'h0700;
      16'd5: a = a | 16'h8000;
      16'd7: a = (a & 16'h8800) | ((a & 16'h7000) >> 4) | ((a & 16'h0700) << 4);
      16'd25: a = a & 16'h7FFF;
      16'd30: begin fg = 16'h000; fg_v = 1'b1; end
      16'd31: begin fg = 16'h400; fg_v = 1'b1; end
      16'd32: begin fg = 16'h200; fg_v = 1'b1; end
      16'd33: begin fg = 16'h600; fg_v = 1'b1; end
      16'd34: begin fg = 16'h100; fg_v = 1'b1; end
      16'd35: begin fg = 16'h500; fg_v = 1'b1; end
      16'd36: begin fg = 16'h300; fg_v = 1'b1; end
      16'd37: begin fg = 16'h700; fg_v = 1'b1; end
      16'd40: begin bg = 16'h0000; bg_v = 1'b1; end
      16'd41: begin bg = 16'h4000; bg_v = 1'b1; end
      16'd42: begin bg = 16'h2000; bg_v = 1'b1; end
      16'd43: begin bg = 16'h6000; bg_v = 1'b1; end
      16'd44: begin bg = 16'h1000; bg_v = 1'b1; end
      16'd45: begin bg = 16'h5000; bg_v = 1'b1; end
      16'd46: begin bg = 16'h3000; bg_v = 1'b1; end
      16'd47: begin bg = 16'h7000; bg_v = 1'b1; end
      16'd90: begin fg = 16'h800; fg_v = 1'b1; end
      16'd91: begin fg = 16'hC00; fg_v = 1'b1; end
      16'd92: begin fg = 16'hA00; fg_v = 1'b1; end
      16'd93: begin fg = 16'hE00; fg_v = 1'b1; end
      16'd94: begin fg = 16'h900; fg_v = 1'b1; end
      16'd95: begin fg = 16'hD00; fg_v = 1'b1; end
      16'd96: begin fg = 16'hB00; fg_v = 1'b1; end
      16'd97: begin fg = 16'hF00; fg_v = 1'b1; end
      default: ;
    endcase
    if (fg_v) a = (a & 16'hF000) | fg;
    if (bg_v) a = (a & 16'h8F00) | bg;
    return a;
  endfunction

endpackage

// ----- sv/atcw_if.sv -----
// Valid/ready channel interfaces for the console writer's requests and results.
interface atcw_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       last_in_write;
  modport source (output valid, data_byte, last_in_write, input ready);
  modport sink (input valid, data_byte, last_in_write, output ready);
endinterface

interface atcw_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  kind;
  logic [10:0] cell_index;
  logic [15:0] cell_value;
  logic [15:0] cursor_position;
  logic        last;
  modport source (output valid, kind, cell_index, cell_value, cursor_position, last,
                  input ready);
  modport sink (input valid, kind, cell_index, cell_value, cursor_position, last,
                output ready);
endinterface

// ----- sv/atcw_datapath.sv -----
// Datapath of the console writer: position, attribute, parser state and argument registers.
module atcw_datapath #(
  parameter int unsigned COLUMNS = atcw_pkg::Columns,
  parameter int unsigned ROWS = atcw_pkg::Rows,
  parameter int unsigned MAX_ARGS = atcw_pkg::MaxArgs
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic [7:0]          byte_i,
  input  logic                lastw_i,
  input  atcw_pkg::cmd_t      cmd_i,
  input  logic [$clog2(MAX_ARGS)-1:0] sgr_sel_i,
  output atcw_pkg::status_t   status_o,
  output logic [$clog2(MAX_ARGS+1)-1:0] sgr_cnt_o,
  output atcw_pkg::result_t   cell_res_o,
  output atcw_pkg::result_t   cursor_res_o
);
  localparam int unsigned SelW = $clog2(MAX_ARGS);
  localparam int unsigned CntW = $clog2(MAX_ARGS + 1);
  localparam int unsigned PW = atcw_pkg::PosW;
  localparam int unsigned AW = atcw_pkg::ArgW;
  localparam logic [PW-1:0] Limit = PW'((ROWS - 2) * COLUMNS);
  localparam logic [PW-1:0] Cols = PW'(COLUMNS);

  logic [PW-1:0] pos_q, pos_d;
  logic [15:0] attr_q, attr_d;
  logic [1:0] phase_q, phase_d;
  logic [1:0] skip_q, skip_d;
  logic [CntW-1:0] cnt_q, cnt_d;
  logic [AW-1:0] args_q [MAX_ARGS];
  logic [AW-1:0] args_d [MAX_ARGS];
  logic [7:0] col_q, col_d;
  logic sgr_q, sgr_d, cur_q, cur_d, cell_q, cell_d;
  logic [15:0] cell_val_q, cell_val_d;
  logic [PW-1:0] cell_idx_q, cell_idx_d;
  logic [15:0] curpos_q, curpos_d;
  logic [CntW-1:0] sgr_cnt_q, sgr_cnt_d;

  always_comb begin
    logic plain;
    logic [AW+3:0] acc;
    logic [CntW-1:0] c1;
    pos_d = pos_q;
    attr_d = attr_q;
    phase_d = phase_q;
    skip_d = skip_q;
    cnt_d = cnt_q;
    args_d = args_q;
    col_d = col_q;
    sgr_d = sgr_q;
    cur_d = cur_q;
    cell_d = cell_q;
    cell_val_d = cell_val_q;
    cell_idx_d = cell_idx_q;
    curpos_d = curpos_q;
    sgr_cnt_d = sgr_cnt_q;
    plain = 1'b1;
    acc = '0;
    c1 = '0;
    if (cmd_i.byte_load) begin
      sgr_d = 1'b0;
      cur_d = 1'b0;
      cell_d = 1'b0;
      if (skip_q != 2'd0) begin
        if (byte_i[7:6] == 2'b10) begin
          skip_d = skip_q - 2'd1;
          plain = 1'b0;
        end else begin
          skip_d = 2'd0;
        end
      end else if (phase_q == atcw_pkg::PhaseEsc) begin
        if (byte_i == 8'h5B) begin
          phase_d = atcw_pkg::PhaseCsi;
          for (int i = 0; i < MAX_ARGS; i++) args_d[i] = '0;
          cnt_d = '0;
          plain = 1'b0;
        end else begin
          phase_d = atcw_pkg::PhaseText;
        end
      end else if (phase_q == atcw_pkg::PhaseCsi) begin
        plain = 1'b0;
        if (byte_i >= 8'h30 && byte_i <= 8'h39) begin
          if (cnt_q < CntW'(MAX_ARGS)) begin
            acc = {args_q[cnt_q[SelW-1:0]], 3'b000} + {2'b00, args_q[cnt_q[SelW-1:0]], 1'b0}
                  + (AW+4)'(byte_i[3:0]);
            args_d[cnt_q[SelW-1:0]] = (acc > (AW+4)'(16'hFFFF)) ? 16'hFFFF : acc[AW-1:0];
          end
        end else if (byte_i == 8'h3B) begin
          if (cnt_q < CntW'(MAX_ARGS)) cnt_d = cnt_q + 1'b1;
        end else begin
          c1 = (cnt_q < CntW'(MAX_ARGS)) ? cnt_q + 1'b1 : CntW'(MAX_ARGS);
          if (byte_i == 8'h6D) begin
            sgr_d = 1'b1;
            sgr_cnt_d = c1;
          end else if (byte_i == 8'h48 || byte_i == 8'h66) begin
            cur_d = 1'b1;
            curpos_d = args_q[0] * 16'(COLUMNS) + args_q[1];
          end
          phase_d = atcw_pkg::PhaseText;
        end
      end
      if (plain) begin
        if (byte_i[7]) begin
          cell_d = 1'b1;
          cell_idx_d = pos_q;
          cell_val_d = 16'h003F | attr_q;
          pos_d = pos_q + 1'b1;
          col_d = (col_q == 8'(COLUMNS - 1)) ? 8'd0 : col_q + 8'd1;
          if (byte_i[7:5] == 3'b110) skip_d = 2'd1;
          else if (byte_i[7:4] == 4'b1110) skip_d = 2'd2;
          else if (byte_i[7:3] == 5'b11110) skip_d = 2'd3;
          else skip_d = 2'd0;
        end else if (byte_i < 8'h20) begin
          if (byte_i == 8'h0A) begin
            pos_d = pos_q + Cols - PW'(col_q);
            col_d = 8'd0;
          end else if (byte_i == 8'h1B) begin
            phase_d = atcw_pkg::PhaseEsc;
          end
        end else begin
          cell_d = 1'b1;
          cell_idx_d = pos_q;
          cell_val_d = {8'h00, byte_i} | attr_q;
          pos_d = pos_q + 1'b1;
          col_d = (col_q == 8'(COLUMNS - 1)) ? 8'd0 : col_q + 8'd1;
        end
      end
      if (lastw_i) begin
        phase_d = atcw_pkg::PhaseText;
        skip_d = 2'd0;
      end
    end
    if (cmd_i.sgr_apply) attr_d = atcw_pkg::apply_sgr(attr_q, args_q[sgr_sel_i]);
    if (cmd_i.scroll) pos_d = pos_q - Cols;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      attr_q <= atcw_pkg::AttrReset;
      phase_q <= atcw_pkg::PhaseText;
      skip_q <= '0;
      cnt_q <= '0;
      for (int i = 0; i < MAX_ARGS; i++) args_q[i] <= '0;
      col_q <= '0;
      sgr_q <= 1'b0;
      cur_q <= 1'b0;
      cell_q <= 1'b0;
      sgr_cnt_q <= '0;
    end else begin
      pos_q <= pos_d;
      attr_q <= attr_d;
      phase_q <= phase_d;
      skip_q <= skip_d;
      cnt_q <= cnt_d;
      args_q <= args_d;
      col_q <= col_d;
      sgr_q <= sgr_d;
      cur_q <= cur_d;
      cell_q <= cell_d;
      sgr_cnt_q <= sgr_cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cell_val_q <= cell_val_d;
    cell_idx_q <= cell_idx_d;
    curpos_q <= curpos_d;
  end

  assign status_o.need_sgr = sgr_q;
  assign status_o.need_cursor = cur_q;
  assign status_o.need_cell = cell_q;
  assign status_o.need_scroll = pos_q > Limit;
  assign sgr_cnt_o = sgr_cnt_q;

  assign cell_res_o = '{kind: atcw_pkg::KindCell, cell_index: cell_idx_q,
                        cell_value: cell_val_q, cursor_position: 16'd0, last: 1'b0};
  assign cursor_res_o = '{kind: atcw_pkg::KindCursor, cell_index: 11'd0,
                          cell_value: 16'd0, cursor_position: curpos_q, last: 1'b0};
endmodule

// ----- sv/atcw_ctrl.sv -----
// Controller of the console writer: sequences decode, colour updates and result delivery.
module atcw_ctrl #(
  parameter int unsigned MAX_ARGS = atcw_pkg::MaxArgs
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_ready_o,
  input  atcw_pkg::status_t status_i,
  input  logic [$clog2(MAX_ARGS+1)-1:0] sgr_cnt_i,
  input  atcw_pkg::result_t cell_res_i,
  input  atcw_pkg::result_t cursor_res_i,
  output atcw_pkg::cmd_t    cmd_o,
  output logic [$clog2(MAX_ARGS)-1:0] sgr_sel_o,
  output logic              out_valid_o,
  input  logic              out_ready_i,
  output atcw_pkg::result_t out_res_o
);
  localparam int unsigned SelW = $clog2(MAX_ARGS);
  localparam int unsigned CntW = $clog2(MAX_ARGS + 1);
  localparam logic [1:0] StIdle = 2'd0;
  localparam logic [1:0] StDecide = 2'd1;
  localparam logic [1:0] StSgr = 2'd2;
  localparam logic [1:0] StScroll = 2'd3;

  logic [1:0] state_q, state_d;
  logic [CntW-1:0] idx_q, idx_d;
  logic ov_q, ov_d;
  atcw_pkg::result_t res_q, res_d;

  assign sgr_sel_o = idx_q[SelW-1:0];
  assign out_valid_o = ov_q;
  assign out_res_o = res_q;

  always_comb begin
    logic free;
    state_d = state_q;
    idx_d = idx_q;
    ov_d = ov_q;
    res_d = res_q;
    cmd_o = '0;
    in_ready_o = 1'b0;
    free = !ov_q || out_ready_i;
    if (ov_q && out_ready_i) ov_d = 1'b0;
    unique case (state_q)
      StIdle: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.byte_load = 1'b1;
          state_d = StDecide;
        end
      end
      StDecide: begin
        if (status_i.need_sgr) begin
          idx_d = '0;
          state_d = StSgr;
        end else if (status_i.need_cell || status_i.need_cursor) begin
          if (free) begin
            ov_d = 1'b1;
            res_d = status_i.need_cell ? cell_res_i : cursor_res_i;
            res_d.last = !status_i.need_scroll;
            state_d = status_i.need_scroll ? StScroll : StIdle;
          end
        end else begin
          state_d = status_i.need_scroll ? StScroll : StIdle;
        end
      end
      StSgr: begin
        cmd_o.sgr_apply = 1'b1;
        idx_d = idx_q + 1'b1;
        if (idx_q + 1'b1 >= sgr_cnt_i) state_d = StIdle;
      end
      StScroll: begin
        if (free) begin
          ov_d = 1'b1;
          res_d = '{kind: atcw_pkg::KindScroll, cell_index: 11'd0, cell_value: 16'd0,
                    cursor_position: 16'd0, last: 1'b1};
          cmd_o.scroll = 1'b1;
          state_d = StIdle;
        end
      end
      default: state_d = StIdle;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
      idx_q <= '0;
      ov_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q <= idx_d;
      ov_q <= ov_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_q <= res_d;
  end
endmodule

// ----- sv/ansi_text_console_writer.sv -----
// Top level of the ANSI text console writer.
// The block takes one byte request at a time on in_req (data_byte, last_in_write) and
// returns zero, one or two results on out_res: cell writes, scroll events and cursor sets.
// A byte is accepted when valid and ready are high together at a rising clock edge.
// A plain byte is decoded in the idle state into the position, attribute and parser
// registers, and its result is loaded into the result register in the decide state.
// A byte that causes a scroll event then passes through the scroll state.  A final 'm'
// of an escape sequence applies the stored colour arguments, at most MAX_ARGS of them,
// one per cycle in the SGR state.  The block holds one result in its output register;
// if the receiver stalls, that result stays in place and the controller waits before it
// loads the next one, so nothing is lost.  A new byte is taken while the last result of
// the previous byte still waits in the output register.
// Reset is asynchronous and active low: it sets the write position to zero, the
// attribute to light grey on black, and clears the parser and the output valid flag.
module ansi_text_console_writer #(
  parameter int unsigned COLUMNS = atcw_pkg::Columns,
  parameter int unsigned ROWS = atcw_pkg::Rows,
  parameter int unsigned MAX_ARGS = atcw_pkg::MaxArgs
) (
  input logic clk_i,
  input logic rst_ni,
  atcw_in_if.sink in_req,
  atcw_out_if.source out_res
);
  atcw_pkg::cmd_t cmd;
  atcw_pkg::status_t status;
  atcw_pkg::result_t cell_res, cursor_res, res;
  logic [$clog2(MAX_ARGS)-1:0] sgr_sel;
  logic [$clog2(MAX_ARGS+1)-1:0] sgr_cnt;

  atcw_datapath #(.COLUMNS(COLUMNS), .ROWS(ROWS), .MAX_ARGS(MAX_ARGS)) u_dp (
    .clk_i, .rst_ni,
    .byte_i(in_req.data_byte), .lastw_i(in_req.last_in_write),
    .cmd_i(cmd), .sgr_sel_i(sgr_sel), .status_o(status), .sgr_cnt_o(sgr_cnt),
    .cell_res_o(cell_res), .cursor_res_o(cursor_res)
  );

  atcw_ctrl #(.MAX_ARGS(MAX_ARGS)) u_ctrl (
    .clk_i, .rst_ni,
    .in_valid_i(in_req.valid), .in_ready_o(in_req.ready),
    .status_i(status), .sgr_cnt_i(sgr_cnt), .cell_res_i(cell_res),
    .cursor_res_i(cursor_res), .cmd_o(cmd), .sgr_sel_o(sgr_sel),
    .out_valid_o(out_res.valid), .out_ready_i(out_res.ready), .out_res_o(res)
  );

  assign out_res.kind = res.kind;
  assign out_res.cell_index = res.cell_index;
  assign out_res.cell_value = res.cell_value;
  assign out_res.cursor_position = res.cursor_position;
  assign out_res.last = res.last;
endmodule
